FILE: design/jsu_pkg.sv
// Shared types and codes for the JSON string unescape block.
// Used by the front, queue, back, top level and checker; no dependencies.
package jsu_pkg;

  // Result status codes as they appear on out_tuser
  localparam logic [1:0] ST_BYTE   = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  // Command kinds passed from the front to the back
  localparam logic [1:0] KIND_RAW    = 2'd0;  // one byte, passed as is
  localparam logic [1:0] KIND_CP     = 2'd1;  // code point, expand to UTF-8
  localparam logic [1:0] KIND_CLOSED = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam int CP_W = 21;

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]      kind;
    logic [CP_W-1:0] value;
  } cmd_t;

endpackage

FILE: design/jsu_front.sv
// Front end: parses one input byte per transfer and issues at most one command.
// Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       input_end,
  output logic       push,
  output cmd_t       cmd
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_BODY    = 3'd1;
  localparam logic [2:0] PH_ESC     = 3'd2;
  localparam logic [2:0] PH_HEX     = 3'd3;
  localparam logic [2:0] PH_PAIR_BS = 3'd4;
  localparam logic [2:0] PH_PAIR_U  = 3'd5;
  localparam logic [2:0] PH_HEX_LO  = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic        gen;
  logic        fail;
  logic        hex_ok;
  logic [3:0]  digit;
  logic [15:0] acc;
  logic        ws;

  always_comb begin
    hex_ok = 1'b1;
    digit  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      digit = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      digit = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc = {hex_r[11:0], digit};
  assign ws  = (in_byte == 8'h20) || (in_byte == 8'h09) ||
               (in_byte == 8'h0A) || (in_byte == 8'h0D);

  always_comb begin
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    cnt_nxt   = cnt_r;
    hs_nxt    = hs_r;
    gen       = 1'b0;
    fail      = 1'b0;
    cmd       = '0;
    if (phase_r == PH_IDLE || phase_r > PH_HEX_LO) begin
      phase_nxt = PH_IDLE;
      if (!input_end && !ws) begin
        if (in_byte == 8'h22) phase_nxt = PH_BODY;
        else fail = 1'b1;
      end
    end else if (input_end) begin
      fail = 1'b1;
    end else begin
      case (phase_r)
        PH_BODY: begin
          if (in_byte == 8'h22) begin
            gen      = 1'b1;
            cmd.kind = KIND_CLOSED;
            phase_nxt = PH_IDLE;
            hex_nxt  = '0;
            cnt_nxt  = '0;
            hs_nxt   = '0;
          end else if (in_byte < 8'h20) begin
            fail = 1'b1;
          end else if (in_byte == 8'h5C) begin
            phase_nxt = PH_ESC;
          end else begin
            gen       = 1'b1;
            cmd.kind  = KIND_RAW;
            cmd.value = CP_W'(in_byte);
          end
        end
        PH_ESC: begin
          phase_nxt = PH_BODY;
          gen       = 1'b1;
          cmd.kind  = KIND_RAW;
          case (in_byte)
            8'h22, 8'h5C, 8'h2F: cmd.value = CP_W'(in_byte);
            8'h62: cmd.value = CP_W'(8'h08);
            8'h66: cmd.value = CP_W'(8'h0C);
            8'h6E: cmd.value = CP_W'(8'h0A);
            8'h72: cmd.value = CP_W'(8'h0D);
            8'h74: cmd.value = CP_W'(8'h09);
            8'h75: begin
              gen       = 1'b0;
              phase_nxt = PH_HEX;
              hex_nxt   = '0;
              cnt_nxt   = '0;
            end
            default: begin
              gen  = 1'b0;
              fail = 1'b1;
            end
          endcase
        end
        PH_HEX, PH_HEX_LO: begin
          if (!hex_ok) begin
            fail = 1'b1;
          end else if (cnt_r != 2'd3) begin
            hex_nxt = acc;
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            hex_nxt = '0;
            cnt_nxt = '0;
            if (phase_r == PH_HEX) begin
              if (acc[15:10] == 6'b110110) begin
                hs_nxt    = acc[9:0];
                phase_nxt = PH_PAIR_BS;
              end else if (acc[15:10] == 6'b110111) begin
                fail = 1'b1;
              end else begin
                gen       = 1'b1;
                cmd.kind  = KIND_CP;
                cmd.value = CP_W'(acc);
                phase_nxt = PH_BODY;
              end
            end else begin
              if (acc[15:10] != 6'b110111) begin
                fail = 1'b1;
              end else begin
                gen       = 1'b1;
                cmd.kind  = KIND_CP;
                cmd.value = CP_W'(21'h10000) + CP_W'({hs_r, acc[9:0]});
                hs_nxt    = '0;
                phase_nxt = PH_BODY;
              end
            end
          end
        end
        PH_PAIR_BS: begin
          if (in_byte == 8'h5C) phase_nxt = PH_PAIR_U;
          else fail = 1'b1;
        end
        default: begin
          if (in_byte == 8'h75) begin
            phase_nxt = PH_HEX_LO;
            hex_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            fail = 1'b1;
          end
        end
      endcase
    end
    // drop all string state on a fault
    if (fail) begin
      phase_nxt = PH_IDLE;
      hex_nxt   = '0;
      cnt_nxt   = '0;
      hs_nxt    = '0;
      gen       = 1'b1;
      cmd.kind  = KIND_ERROR;
      cmd.value = '0;
    end
  end

  assign push = accept && gen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hex_r   <= '0;
      cnt_r   <= '0;
      hs_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
      cnt_r   <= cnt_nxt;
      hs_r    <= hs_nxt;
    end
  end

endmodule

FILE: design/jsu_fifo.sv
// Command queue between front and back: registered count, one write, one read.
// Depends on jsu_pkg for the command type.
module jsu_fifo import jsu_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic not_empty,
  output logic full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CW'(DEPTH));
  assign rd_cmd    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    if (pop)  rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/jsu_back.sv
// Back end: expands each command into one to four result transfers (UTF-8 bytes).
// Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  logic       busy_r;
  logic [7:0] byte_r [4];
  logic [7:0] byte_nxt [4];
  logic [1:0] n_r, n_nxt;
  logic [1:0] st_r, st_nxt;
  logic [1:0] idx_r;
  logic       done;
  logic [CP_W-1:0] v;

  assign v = head.value;

  // encode the queue head so it is ready to load
  always_comb begin
    byte_nxt[0] = 8'h00;
    byte_nxt[1] = 8'h00;
    byte_nxt[2] = 8'h00;
    byte_nxt[3] = 8'h00;
    n_nxt       = 2'd0;
    st_nxt      = ST_BYTE;
    case (head.kind)
      KIND_RAW: byte_nxt[0] = v[7:0];
      KIND_CP: begin
        if (v < CP_W'(21'h80)) begin
          byte_nxt[0] = v[7:0];
        end else if (v < CP_W'(21'h800)) begin
          n_nxt       = 2'd1;
          byte_nxt[0] = {3'b110, v[10:6]};
          byte_nxt[1] = {2'b10, v[5:0]};
        end else if (v < CP_W'(21'h10000)) begin
          n_nxt       = 2'd2;
          byte_nxt[0] = {4'b1110, v[15:12]};
          byte_nxt[1] = {2'b10, v[11:6]};
          byte_nxt[2] = {2'b10, v[5:0]};
        end else begin
          n_nxt       = 2'd3;
          byte_nxt[0] = {5'b11110, v[20:18]};
          byte_nxt[1] = {2'b10, v[17:12]};
          byte_nxt[2] = {2'b10, v[11:6]};
          byte_nxt[3] = {2'b10, v[5:0]};
        end
      end
      KIND_CLOSED: st_nxt = ST_CLOSED;
      default:     st_nxt = ST_ERROR;
    endcase
  end

  assign done = out_tready && (idx_r == n_r);
  assign pop  = head_valid && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r <= byte_nxt;
      n_r    <= n_nxt;
      st_r   <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && out_tready) begin
      if (done) busy_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = byte_r[idx_r];
  assign out_tuser  = st_r;
  assign out_tlast  = (idx_r == n_r);

endmodule

FILE: design/json_string_unescape_utf8.sv
// JSON string unescape to UTF-8.
// Input channel: one raw byte per transfer (in_tdata); in_tuser[0] marks end
// of input, in which case the byte is ignored. Leading space, tab, CR and LF
// are skipped until an opening quote; the string body is then decoded.
// Result channel: out_tdata is a UTF-8 byte, out_tuser the status (0 byte,
// 1 string closed, 2 error), out_tlast the final result of one input byte.
// A \uXXXX escape yields 1 to 3 transfers; a surrogate pair yields 4.
// Throughput: one input byte per cycle while the command queue is not full.
// The front parses a byte in the cycle it is taken; the back sends one result
// per cycle while out_tready is high, and the command queue absorbs the input
// while the bytes of a multi-byte code point go out. Each command is written
// into the queue, then popped into the registered output stage.
// in_tready drops only when the command queue is full, so a stalled receiver
// backs up the input after DEPTH queued commands plus the one held in the
// output stage; bytes that issue no command do not fill the queue.
// Reset (rst_n low, synchronous) returns the parser to idle and empties the
// queue and the output stage.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] input_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);

  logic accept;
  logic push;
  logic pop;
  logic q_valid;
  logic q_full;
  cmd_t wr_cmd;
  cmd_t head;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_tdata),
    .input_end (in_tuser[0]),
    .push      (push),
    .cmd       (wr_cmd)
  );

  jsu_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_cmd    (wr_cmd),
    .pop       (pop),
    .rd_cmd    (head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (q_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: design/jsu_checker.sv
// Port-level checks for json_string_unescape_utf8, attached by bind.
// Depends on jsu_pkg for the status codes.
module jsu_checker import jsu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // close and error are single transfers with a zero byte
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_BYTE |-> out_tlast && out_tdata == 8'h00)
    else $error("close or error result malformed");

  // continuation bytes of a code point are already buffered
  a_cont_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tuser == ST_BYTE)
    else $error("multi-byte sequence broken");

  // a byte that is not the last of its group is a UTF-8 lead or continuation
  a_lead_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == ST_BYTE && out_tdata[7] == 1'b1)
    else $error("non-final result is not a multi-byte UTF-8 byte");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Stream-level test of json_string_unescape_utf8: a byte-wise JSON string decoder model
// predicts every UTF-8 / closed / error transfer, which is checked against the result channel.
// Depends on jsu_pkg for the status codes and on the RTL of the block.
module tb_top;
  import jsu_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    P_IDLE, P_BODY, P_ESC, P_HEX, P_PAIR_BS, P_PAIR_U, P_HEX_LO
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic [0:0] in_tuser = 1'b0;    // [0] input_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic [1:0] out_tuser;          // [1:0] status
  logic       out_tlast;

  // decoder copy used for prediction
  parse_phase_e ph = P_IDLE;
  logic [15:0]  hex_acc = 16'h0;
  logic [1:0]   hex_cnt = 2'd0;
  logic [9:0]   hi_bits = 10'h0;

  result_t step_res[$];        // results of the byte being predicted
  result_t pending_results[$]; // decoded transfers not yet seen on the output

  logic smooth = 1'b0;         // no idling on either side while set
  int   hold_left = 0;
  int   rdy_gap = 0;
  int   idle_cnt = 0;
  int   n_in = 0, n_out = 0, n_closed = 0, n_err = 0, n_blocked = 0;
  int   mism_cnt = 0;

  json_string_unescape_utf8 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // 0..15 for a hex digit, 16 otherwise
  function automatic logic [4:0] nibble_of(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 8'd10);
    if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  task automatic add_result(input logic [7:0] data, input logic [1:0] status);
    result_t r;
    r.data = data;
    r.status = status;
    r.last = 1'b0;
    step_res.push_back(r);
  endtask

  task automatic push_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_result(cp[7:0], ST_BYTE);
    end else if (cp < 21'h800) begin
      add_result({3'b110, cp[10:6]}, ST_BYTE);
      add_result({2'b10, cp[5:0]}, ST_BYTE);
    end else if (cp < 21'h10000) begin
      add_result({4'b1110, cp[15:12]}, ST_BYTE);
      add_result({2'b10, cp[11:6]}, ST_BYTE);
      add_result({2'b10, cp[5:0]}, ST_BYTE);
    end else begin
      add_result({5'b11110, cp[20:18]}, ST_BYTE);
      add_result({2'b10, cp[17:12]}, ST_BYTE);
      add_result({2'b10, cp[11:6]}, ST_BYTE);
      add_result({2'b10, cp[5:0]}, ST_BYTE);
    end
  endtask

  task automatic clear_decoder();
    ph = P_IDLE;
    hex_acc = 16'h0;
    hex_cnt = 2'd0;
    hi_bits = 10'h0;
  endtask

  // Advance the decoder copy by one accepted byte and queue what it produces.
  task automatic decode_step(input logic [7:0] b, input logic eoi);
    logic        fail;
    logic [4:0]  dig;
    logic [15:0] cpv;
    result_t     r;
    fail = 1'b0;
    step_res.delete();
    if (ph == P_IDLE) begin
      if (eoi || b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
        // skip
      end else if (b == CH_QUOTE) begin
        ph = P_BODY;
      end else begin
        fail = 1'b1;
      end
    end else if (eoi) begin
      fail = 1'b1;
    end else begin
      case (ph)
        P_BODY: begin
          if (b == CH_QUOTE) begin
            add_result(8'h00, ST_CLOSED);
            clear_decoder();
          end else if (b < 8'h20) begin
            fail = 1'b1;
          end else if (b == CH_BSLASH) begin
            ph = P_ESC;
          end else begin
            add_result(b, ST_BYTE);
          end
        end
        P_ESC: begin
          ph = P_BODY;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(b, ST_BYTE);
            8'h62: add_result(8'h08, ST_BYTE);
            8'h66: add_result(8'h0C, ST_BYTE);
            8'h6E: add_result(CH_LF, ST_BYTE);
            8'h72: add_result(CH_CR, ST_BYTE);
            8'h74: add_result(CH_TAB, ST_BYTE);
            CH_U: begin
              ph = P_HEX;
              hex_acc = 16'h0;
              hex_cnt = 2'd0;
            end
            default: fail = 1'b1;
          endcase
        end
        P_HEX, P_HEX_LO: begin
          dig = nibble_of(b);
          if (dig[4]) begin
            fail = 1'b1;
          end else begin
            hex_acc = {hex_acc[11:0], dig[3:0]};
            if (hex_cnt != 2'd3) begin
              hex_cnt = hex_cnt + 2'd1;
            end else begin
              hex_cnt = 2'd0;
              cpv = hex_acc;
              hex_acc = 16'h0;
              if (ph == P_HEX) begin
                if (cpv >= 16'hD800 && cpv <= 16'hDBFF) begin
                  hi_bits = cpv[9:0];
                  ph = P_PAIR_BS;
                end else if (cpv >= 16'hDC00 && cpv <= 16'hDFFF) begin
                  fail = 1'b1;
                end else begin
                  push_code_point({5'd0, cpv});
                  ph = P_BODY;
                end
              end else if (cpv < 16'hDC00 || cpv > 16'hDFFF) begin
                fail = 1'b1;
              end else begin
                push_code_point(21'h10000 + {1'b0, hi_bits, cpv[9:0]});
                hi_bits = 10'h0;
                ph = P_BODY;
              end
            end
          end
        end
        P_PAIR_BS: begin
          if (b == CH_BSLASH) ph = P_PAIR_U;
          else fail = 1'b1;
        end
        default: begin
          if (b == CH_U) begin
            ph = P_HEX_LO;
            hex_acc = 16'h0;
            hex_cnt = 2'd0;
          end else begin
            fail = 1'b1;
          end
        end
      endcase
    end
    if (fail) begin
      clear_decoder();
      step_res.delete();
      add_result(8'h00, ST_ERROR);
    end
    foreach (step_res[i]) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      pending_results.push_back(r);
    end
  endtask

  // Offer one byte, hold it until the transfer, then predict.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = smooth ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= b;
    in_tuser <= eoi;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) begin
      n_blocked++;
      @(posedge clk);
    end
    decode_step(b, eoi);
    n_in++;
  endtask

  task automatic send_hex4(input logic [15:0] v);
    logic upper;
    upper = 1'($urandom_range(0, 1));
    send_item(hex_char(v[15:12], upper), 1'b0);
    send_item(hex_char(v[11:8], upper), 1'b0);
    send_item(hex_char(v[7:4], upper), 1'b0);
    send_item(hex_char(v[3:0], upper), 1'b0);
  endtask

  task automatic send_u_escape(input logic [15:0] v);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_U, 1'b0);
    send_hex4(v);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  // One broken piece of a string body, which returns the block to idle, then up to two noise bytes.
  task automatic send_fault();
    logic [7:0] b;
    logic [4:0] nb;
    int         k;
    case ($urandom_range(0, 7))
      0: send_item(8'($urandom_range(0, 8'h1F)), 1'b0);
      1: begin
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74,
                         CH_U});
        send_item(CH_BSLASH, 1'b0);
        send_item(b, 1'b0);
      end
      2: begin
        k = $urandom_range(0, 3);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_U, 1'b0);
        repeat (k)
          send_item(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
        do begin
          b = 8'($urandom_range(0, 255));
          nb = nibble_of(b);
        end while (!nb[4]);
        send_item(b, 1'b0);
      end
      3: send_u_escape(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
      4: begin
        send_u_escape(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
        do b = 8'($urandom_range(0, 255));
        while (b == CH_BSLASH);
        send_item(b, 1'b0);
      end
      5: begin
        send_u_escape(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
        send_item(CH_BSLASH, 1'b0);
        do b = 8'($urandom_range(0, 255));
        while (b == CH_U);
        send_item(b, 1'b0);
      end
      6: begin
        send_u_escape(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
        if ($urandom_range(0, 1)) send_u_escape(16'($urandom_range(0, 16'hDBFF)));
        else send_u_escape(16'($urandom_range(16'hE000, 16'hFFFF)));
      end
      default: begin
        // end of input, sometimes in the middle of an escape
        k = $urandom_range(0, 3);
        if (k >= 1) send_item(CH_BSLASH, 1'b0);
        if (k >= 2) send_item(CH_U, 1'b0);
        if (k >= 3) send_item(hex_char(4'($urandom_range(0, 15)), 1'b0), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    send_noise($urandom_range(0, 2));
  endtask

  // kind: 0 random mix, 4 surrogate pairs only (a fault can still be inserted)
  task automatic send_random_string(input int kind);
    logic [7:0] ws [4];
    logic [7:0] esc [8];
    logic [7:0] b;
    int         n_elem, fault_at, sel;
    ws = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    esc = '{CH_QUOTE, CH_BSLASH, CH_SLASH, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
    repeat ($urandom_range(0, 2)) send_item(ws[$urandom_range(0, 3)], 1'b0);
    send_item(CH_QUOTE, 1'b0);
    n_elem = $urandom_range(0, 8);
    fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_elem) : -1;
    for (int i = 0; i < n_elem; i++) begin
      if (i == fault_at) begin
        send_fault();
        return;
      end
      sel = (kind == 4) ? 4 : $urandom_range(0, 4);
      case (sel)
        0: begin
          do b = 8'($urandom_range(8'h20, 8'h7F));
          while (b == CH_QUOTE || b == CH_BSLASH);
          send_item(b, 1'b0);
        end
        1: send_item(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
        2: begin
          send_item(CH_BSLASH, 1'b0);
          send_item(esc[$urandom_range(0, 7)], 1'b0);
        end
        3: begin
          case ($urandom_range(0, 3))
            0: send_u_escape(16'($urandom_range(0, 16'h7F)));
            1: send_u_escape(16'($urandom_range(16'h80, 16'h7FF)));
            2: send_u_escape(16'($urandom_range(16'h800, 16'hD7FF)));
            default: send_u_escape(16'($urandom_range(16'hE000, 16'hFFFF)));
          endcase
        end
        default: begin
          send_u_escape(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
          send_u_escape(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
        end
      endcase
    end
    if (fault_at == n_elem) send_fault();
    else send_item(CH_QUOTE, 1'b0);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // whitespace, end of input and a fault while idle, raw high bytes, largest code point, control byte, open at end
  task automatic test_directed();
    send_item(CH_SPACE, 1'b0); send_item(CH_TAB, 1'b0);
    send_item(CH_CR, 1'b0);    send_item(CH_LF, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h78, 1'b0);
    send_item(CH_QUOTE, 1'b0); send_item(8'hFF, 1'b0); send_item(8'h80, 1'b0);
    send_u_escape(16'hDBFF);
    send_item(CH_BSLASH, 1'b0); send_item(CH_U, 1'b0);
    send_item(8'h64, 1'b0); send_item(8'h66, 1'b0); send_item(8'h46, 1'b0);
    send_item(8'h66, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_QUOTE, 1'b0); send_item(8'h00, 1'b0);
    send_item(CH_QUOTE, 1'b0); send_item(8'h00, 1'b1);
  endtask

  // back-to-back bytes and results, smallest and edge code points
  task automatic test_smooth();
    smooth <= 1'b1;
    send_item(CH_QUOTE, 1'b0);
    send_u_escape(16'h0000);
    send_u_escape(16'h007F);
    send_u_escape(16'h0080);
    send_u_escape(16'h07FF);
    send_u_escape(16'h0800);
    send_u_escape(16'hFFFF);
    send_u_escape(16'hD800);
    send_u_escape(16'hDC00);
    send_u_escape(16'hDBFF);
    send_u_escape(16'hDFFF);
    send_item(CH_QUOTE, 1'b0);
    repeat (2) send_random_string(0);
    smooth <= 1'b0;
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    stop_at = n_in + n_items;
    while (n_in < stop_at) begin
      if ($urandom_range(0, 9) < 8) send_random_string(0);
      else send_noise($urandom_range(1, 4));
    end
  endtask

  // receiver holds off while code points keep arriving, so the queue fills
  task automatic test_output_holdoff();
    hold_left <= 400;
    repeat (3) send_random_string(4);
  endtask

  // sender stops until every pending result has come out
  task automatic test_drain_pause();
    repeat (3) begin
      send_random_string(0);
      wait_results_drained();
    end
  endtask

  // receiver: random gaps unless smooth, plus the long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rdy_gap > 0) begin
      out_tready <= 1'b0;
      rdy_gap <= rdy_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if (!smooth) rdy_gap <= pick_gap();
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t r;
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (out_tuser == ST_CLOSED) n_closed++;
      if (out_tuser == ST_ERROR) n_err++;
      if (pending_results.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= MAX_REPORTS)
          $display("tb: unexpected result data %02h status %0d last %0b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        r = pending_results.pop_front();
        if (out_tdata !== r.data || out_tuser !== r.status || out_tlast !== r.last) begin
          mism_cnt++;
          if (mism_cnt <= MAX_REPORTS)
            $display("tb: result %0d: expected data %02h status %0d last %0b, got %02h %0d %0b",
                     n_out, r.data, r.status, r.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
  end

  initial begin
    wait (idle_cnt >= STALL_LIMIT);
    $display("tb: no transfer for %0d cycles, %0d results pending",
             STALL_LIMIT, pending_results.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_smooth();
    test_output_holdoff();
    test_drain_pause();
    test_random_traffic(110);
    wait_results_drained();
    repeat (20) @(posedge clk);
    $display("tb: %0d bytes in, %0d results out (%0d strings closed, %0d errors)",
             n_in, n_out, n_closed, n_err);
    $display("tb: input held back %0d cycles, %0d mismatches", n_blocked, mism_cnt);
    if (mism_cnt == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
